### src/spims_pkg.sv
`timescale 1ns / 1ps

package spims_pkg;

    localparam int WORD_BITS_DEF = 16;
    localparam int NARROW_BITS   = 8;
    localparam int DATA_W        = 16;
    localparam int MODE_W        = 2;
    localparam int CPOL_BIT      = 1;
    localparam int CPHA_BIT      = 0;

    localparam logic [NARROW_BITS-1:0] NARROW_ONES = '1;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    typedef struct packed {
        logic              func;
        logic [DATA_W-1:0] tx_word;
        logic              wide;
        logic              keep_select;
        logic              miso;
    } t_in_item;

    typedef struct packed {
        logic              sclk;
        logic              mosi;
        logic              cs_n;
        logic              busy_res;
        logic              done_res;
        logic [DATA_W-1:0] rx_word;
        logic              rejected;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic start_req;
    } t_core_status;

endpackage

### src/spims_if.sv
`timescale 1ns / 1ps

interface spims_in_if;
    logic                 valid;
    logic                 ready;
    spims_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spims_out_if;
    logic                 valid;
    logic                 ready;
    spims_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spims_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [spims_pkg::MODE_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/spims_core.sv
`timescale 1ns / 1ps

module spims_core #(
    parameter int WORD_BITS = spims_pkg::WORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  spims_pkg::t_in_item            i_item,
    input  logic                           i_cfg_we,
    input  logic [spims_pkg::MODE_W-1:0]   i_cfg_mode,
    output spims_pkg::t_out_item           o_result,
    output spims_pkg::t_core_status        o_status
);

    localparam int BW = $clog2(WORD_BITS + 1);
    localparam logic [WORD_BITS-1:0] NARROW_MASK = WORD_BITS'(spims_pkg::NARROW_ONES);
    localparam logic [WORD_BITS-1:0] WIDE_MASK   = '1;
    localparam logic [BW-1:0]        WIDE_CNT    = BW'(WORD_BITS);
    localparam logic [BW-1:0]        NARROW_CNT  = BW'(spims_pkg::NARROW_BITS);

    logic [spims_pkg::MODE_W-1:0] r_mode;
    logic [WORD_BITS-1:0]         r_tx, n_tx;
    logic [WORD_BITS-1:0]         r_rx, n_rx;
    logic [BW-1:0]                r_bits, n_bits;
    logic                         r_half, n_half;
    logic                         r_active, n_active;
    logic                         r_wide, n_wide;
    logic                         r_hold, n_hold;
    logic                         r_sel, n_sel;
    logic                         r_clk, n_clk;

    logic                         cpol;
    logic                         cpha;
    logic [WORD_BITS-1:0]         mask;
    logic [BW-1:0]                total;
    logic [BW-1:0]                bits_dec;
    logic [31:0]                  tx_ext;
    logic [31:0]                  rx_ext;
    logic [WORD_BITS-1:0]         rx_out;
    logic                         done;
    logic                         rejected;

    assign cpol   = r_mode[spims_pkg::CPOL_BIT];
    assign cpha   = r_mode[spims_pkg::CPHA_BIT];
    assign mask   = r_wide ? WIDE_MASK : NARROW_MASK;
    assign total  = r_wide ? WIDE_CNT : NARROW_CNT;
    assign tx_ext = 32'(i_item.tx_word);
    assign bits_dec = (r_bits != '0) ? r_bits - 1'b1 : r_bits;

    always_comb begin
        n_tx     = r_tx;
        n_rx     = r_rx;
        n_bits   = r_bits;
        n_half   = r_half;
        n_active = r_active;
        n_wide   = r_wide;
        n_hold   = r_hold;
        n_sel    = r_sel;
        n_clk    = r_clk;
        done     = 1'b0;
        rejected = 1'b0;
        rx_out   = '0;
        if (i_item.func == spims_pkg::FUNC_START) begin
            if (r_active) begin
                rejected = 1'b1;
            end else begin
                n_wide   = i_item.wide;
                n_tx     = tx_ext[WORD_BITS-1:0] & (i_item.wide ? WIDE_MASK : NARROW_MASK);
                n_rx     = '0;
                n_bits   = i_item.wide ? WIDE_CNT : NARROW_CNT;
                n_half   = 1'b0;
                n_hold   = i_item.keep_select;
                n_sel    = 1'b1;
                n_clk    = cpol;
                n_active = 1'b1;
            end
        end else if (r_active) begin
            n_clk = ~r_clk;
            if (!r_half) begin
                if (!cpha) begin
                    n_rx = {r_rx[WORD_BITS-2:0], i_item.miso} & mask;
                end else if (r_bits != total) begin
                    n_tx = {r_tx[WORD_BITS-2:0], 1'b0} & mask;
                end
                n_half = 1'b1;
            end else begin
                if (!cpha) begin
                    n_tx = {r_tx[WORD_BITS-2:0], 1'b0} & mask;
                end else begin
                    n_rx = {r_rx[WORD_BITS-2:0], i_item.miso} & mask;
                end
                n_half = 1'b0;
                n_bits = bits_dec;
                if (bits_dec == '0) begin
                    n_active = 1'b0;
                    done     = 1'b1;
                    rx_out   = n_rx;
                    if (!r_hold) begin
                        n_sel = 1'b0;
                    end
                end
            end
        end
    end

    assign rx_ext = 32'(rx_out);

    always_comb begin
        o_result.sclk     = n_active ? n_clk : cpol;
        o_result.mosi     = n_active ? (n_wide ? n_tx[WORD_BITS-1]
                                               : n_tx[spims_pkg::NARROW_BITS-1]) : 1'b0;
        o_result.cs_n     = ~n_sel;
        o_result.busy_res = n_active;
        o_result.done_res = done;
        o_result.rx_word  = rx_ext[spims_pkg::DATA_W-1:0];
        o_result.rejected = rejected;
    end

    assign o_status.busy      = r_active;
    assign o_status.start_req = i_accept && (i_item.func == spims_pkg::FUNC_START);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= '0;
            r_tx     <= '0;
            r_rx     <= '0;
            r_bits   <= '0;
            r_half   <= 1'b0;
            r_active <= 1'b0;
            r_wide   <= 1'b0;
            r_hold   <= 1'b0;
            r_sel    <= 1'b0;
            r_clk    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_mode;
            end
            if (i_accept) begin
                r_tx     <= n_tx;
                r_rx     <= n_rx;
                r_bits   <= n_bits;
                r_half   <= n_half;
                r_active <= n_active;
                r_wide   <= n_wide;
                r_hold   <= n_hold;
                r_sel    <= n_sel;
                r_clk    <= n_clk;
            end
        end
    end

endmodule

### src/spims_obuf.sv
`timescale 1ns / 1ps

module spims_obuf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  spims_pkg::t_out_item  i_result,
    input  logic                  i_ready,
    output logic                  o_can_load,
    output logic                  o_valid,
    output spims_pkg::t_out_item  o_result
);

    logic                 r_valid;
    spims_pkg::t_out_item r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

### src/spi_master_shifter.sv
`timescale 1ns / 1ps
// Each request yields one result, which appears the cycle after acceptance.
// Throughput is one request per cycle unless the sink stalls: the shifter
// state updates on acceptance, and the result register frees as it is taken.
// A synchronous active-low reset clears the shifter state, the mode register
// and the result register's valid flag.

module spi_master_shifter #(
    parameter int WORD_BITS = spims_pkg::WORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    spims_in_if.sink           i_in,
    spims_cfg_if.sink          i_cfg,
    spims_out_if.source        o_out
);

    logic                     accept;
    logic                     can_load;
    spims_pkg::t_out_item     result;
    spims_pkg::t_core_status  status;

    assign i_in.ready  = can_load;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_in.valid && can_load;

    spims_core #(
        .WORD_BITS (WORD_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_in.data),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_mode (i_cfg.data),
        .o_result   (result),
        .o_status   (status)
    );

    spims_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_result   (result),
        .i_ready    (o_out.ready),
        .o_can_load (can_load),
        .o_valid    (o_out.valid),
        .o_result   (o_out.data)
    );

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out.valid)
        else $error("accepted request produced no result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input ready while result stalled");

    a_busy_start_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.start_req && status.busy) |=> o_out.data.rejected)
        else $error("start during transfer not flagged");

    a_idle_start_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.start_req && !status.busy) |=>
            (o_out.data.busy_res && !o_out.data.cs_n && !o_out.data.rejected))
        else $error("start while idle did not begin a transfer");

endmodule

### tb/spi_master_shifter_tb.sv
`timescale 1ns / 1ps

module spi_master_shifter_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int CHUNK_ITEMS    = 200;

    localparam logic [spims_pkg::MODE_W-1:0] SPI_MODE0 = 2'd0;
    localparam logic [spims_pkg::MODE_W-1:0] SPI_MODE1 = 2'd1;
    localparam logic [spims_pkg::MODE_W-1:0] SPI_MODE2 = 2'd2;
    localparam logic [spims_pkg::MODE_W-1:0] SPI_MODE3 = 2'd3;

    logic clk;
    logic rst_n;

    spims_in_if  in_bus();
    spims_cfg_if cfg_bus();
    spims_out_if out_bus();

    spi_master_shifter uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .i_cfg   (cfg_bus),
        .o_out   (out_bus)
    );

    spims_pkg::t_in_item  pending_requests[$];
    spims_pkg::t_out_item predicted_outputs[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned requests_taken;
    int unsigned mismatch_count;
    int unsigned stalled_cycles;
    bit          drain_pause;

    logic [spims_pkg::MODE_W-1:0] spi_mode_shadow;
    logic [spims_pkg::DATA_W-1:0] shift_out;
    logic [spims_pkg::DATA_W-1:0] shift_in;
    logic [4:0]                   bits_to_go;
    logic                         second_half;
    logic                         in_transfer;
    logic                         transfer_wide;
    logic                         hold_cs;
    logic                         cs_asserted;
    logic                         sclk_level;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [spims_pkg::DATA_W-1:0] word_mask();
        return transfer_wide ? {spims_pkg::DATA_W{1'b1}}
                             : spims_pkg::DATA_W'(spims_pkg::NARROW_ONES);
    endfunction

    function automatic logic [4:0] word_bits();
        return transfer_wide ? 5'(spims_pkg::WORD_BITS_DEF) : 5'(spims_pkg::NARROW_BITS);
    endfunction

    function automatic spims_pkg::t_out_item predict_spi_item(spims_pkg::t_in_item req);
        spims_pkg::t_out_item res;
        logic                 cpol;
        logic                 cpha;
        res  = '0;
        cpol = spi_mode_shadow[spims_pkg::CPOL_BIT];
        cpha = spi_mode_shadow[spims_pkg::CPHA_BIT];
        if (req.func == spims_pkg::FUNC_START) begin
            if (in_transfer) begin
                res.rejected = 1'b1;
            end else begin
                transfer_wide = req.wide;
                shift_out     = req.tx_word & word_mask();
                shift_in      = '0;
                bits_to_go    = word_bits();
                second_half   = 1'b0;
                hold_cs       = req.keep_select;
                cs_asserted   = 1'b1;
                sclk_level    = cpol;
                in_transfer   = 1'b1;
            end
        end else if (in_transfer) begin
            sclk_level = ~sclk_level;
            if (!second_half) begin
                if (!cpha) begin
                    shift_in = {shift_in[spims_pkg::DATA_W-2:0], req.miso} & word_mask();
                end else if (bits_to_go != word_bits()) begin
                    shift_out = {shift_out[spims_pkg::DATA_W-2:0], 1'b0} & word_mask();
                end
                second_half = 1'b1;
            end else begin
                if (!cpha) begin
                    shift_out = {shift_out[spims_pkg::DATA_W-2:0], 1'b0} & word_mask();
                end else begin
                    shift_in = {shift_in[spims_pkg::DATA_W-2:0], req.miso} & word_mask();
                end
                second_half = 1'b0;
                if (bits_to_go != 0) begin
                    bits_to_go = bits_to_go - 5'd1;
                end
                if (bits_to_go == 0) begin
                    in_transfer  = 1'b0;
                    res.done_res = 1'b1;
                    res.rx_word  = shift_in;
                    if (!hold_cs) begin
                        cs_asserted = 1'b0;
                    end
                end
            end
        end
        res.sclk     = in_transfer ? sclk_level : cpol;
        res.mosi     = in_transfer ? shift_out[transfer_wide ? spims_pkg::WORD_BITS_DEF - 1
                                                             : spims_pkg::NARROW_BITS - 1]
                                   : 1'b0;
        res.cs_n     = ~cs_asserted;
        res.busy_res = in_transfer;
        return res;
    endfunction

    function automatic spims_pkg::t_in_item make_item(logic func,
                                                      logic [spims_pkg::DATA_W-1:0] word,
                                                      logic wide, logic keep, logic miso);
        spims_pkg::t_in_item item;
        item.func        = func;
        item.tx_word     = word;
        item.wide        = wide;
        item.keep_select = keep;
        item.miso        = miso;
        return item;
    endfunction

    function automatic logic [spims_pkg::DATA_W-1:0] random_word();
        int unsigned pick;
        pick = $urandom_range(7);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return '1;
        end
        return spims_pkg::DATA_W'($urandom);
    endfunction

    function automatic spims_pkg::t_in_item random_item(logic func);
        return make_item(func, random_word(), 1'($urandom), 1'($urandom), 1'($urandom));
    endfunction

    task automatic queue_random(int count);
        int                  added;
        int                  n;
        spims_pkg::t_in_item start_req;
        added = 0;
        while (added < count) begin
            if ($urandom_range(99) < 85) begin
                start_req = random_item(spims_pkg::FUNC_START);
                pending_requests.push_back(start_req);
                n = start_req.wide ? 2 * spims_pkg::WORD_BITS_DEF : 2 * spims_pkg::NARROW_BITS;
                repeat (n) pending_requests.push_back(random_item(spims_pkg::FUNC_TICK));
                added += n + 1;
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) pending_requests.push_back(random_item(1'($urandom)));
                added += n;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || in_bus.valid || predicted_outputs.size() != 0) begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic write_spi_mode(logic [spims_pkg::MODE_W-1:0] mode);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= mode;
        do @(posedge clk); while (!cfg_bus.ready);
        spi_mode_shadow = mode;
        cfg_bus.valid  <= 1'b0;
    endtask

    task automatic compare_field(string field, logic [spims_pkg::DATA_W-1:0] want,
                                 logic [spims_pkg::DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                predicted_outputs.push_back(predict_spi_item(in_bus.data));
                requests_taken++;
                if (requests_taken % 128 == 64) begin
                    drain_pause = 1'b1;
                end
            end
            if (drain_pause && predicted_outputs.size() == 0) begin
                drain_pause = 1'b0;
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (pending_requests.size() != 0 && !drain_pause
                        && $urandom_range(99) >= send_idle_pct) begin
                    in_bus.valid <= 1'b1;
                    in_bus.data  <= pending_requests.pop_front();
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        spims_pkg::t_out_item want;
        if (!rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
            if (out_bus.valid && out_bus.ready) begin
                if (predicted_outputs.size() == 0) begin
                    $display("%0t: result with none pending, actual 0x%0h", $time, out_bus.data);
                    mismatch_count++;
                end else begin
                    want = predicted_outputs.pop_front();
                    compare_field("sclk", want.sclk, out_bus.data.sclk);
                    compare_field("mosi", want.mosi, out_bus.data.mosi);
                    compare_field("cs_n", want.cs_n, out_bus.data.cs_n);
                    compare_field("busy", want.busy_res, out_bus.data.busy_res);
                    compare_field("done", want.done_res, out_bus.data.done_res);
                    compare_field("rx_word", want.rx_word, out_bus.data.rx_word);
                    compare_field("rejected", want.rejected, out_bus.data.rejected);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready)) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    initial begin
        while (stalled_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        in_bus.valid    = 1'b0;
        in_bus.data     = '0;
        cfg_bus.valid   = 1'b0;
        cfg_bus.data    = '0;
        out_bus.ready   = 1'b0;
        stalled_cycles  = 0;
        requests_taken  = 0;
        mismatch_count  = 0;
        drain_pause     = 1'b0;
        send_idle_pct   = 7;
        recv_idle_pct   = 47;
        spi_mode_shadow = SPI_MODE0;
        shift_out       = '0;
        shift_in        = '0;
        bits_to_go      = '0;
        second_half     = 1'b0;
        in_transfer     = 1'b0;
        transfer_wide   = 1'b0;
        hold_cs         = 1'b0;
        cs_asserted     = 1'b0;
        sclk_level      = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // An idle tick, a narrow transfer holding chip select with a start request
        // rejected part way through, then a wide transfer left open for a mode change.
        pending_requests.push_back(make_item(spims_pkg::FUNC_TICK, 16'hFFFF, 1'b1, 1'b1, 1'b1));
        pending_requests.push_back(make_item(spims_pkg::FUNC_START, 16'hFF5A, 1'b0, 1'b1, 1'b0));
        pending_requests.push_back(make_item(spims_pkg::FUNC_TICK, 16'h0000, 1'b0, 1'b0, 1'b1));
        pending_requests.push_back(make_item(spims_pkg::FUNC_START, 16'h1234, 1'b1, 1'b0, 1'b0));
        for (int i = 0; i < 15; i++) begin
            pending_requests.push_back(make_item(spims_pkg::FUNC_TICK, 16'h0000, 1'b0, 1'b0,
                                                 1'(i % 3 == 0)));
        end
        pending_requests.push_back(make_item(spims_pkg::FUNC_TICK, 16'h0000, 1'b0, 1'b0, 1'b0));
        pending_requests.push_back(make_item(spims_pkg::FUNC_START, 16'h8001, 1'b1, 1'b0, 1'b1));
        repeat (3) pending_requests.push_back(make_item(spims_pkg::FUNC_TICK, 16'hFFFF,
                                                        1'b1, 1'b1, 1'b1));
        wait_drained();

        write_spi_mode(SPI_MODE3);
        queue_random(CHUNK_ITEMS);
        wait_drained();

        send_idle_pct = 47;
        recv_idle_pct = 7;
        write_spi_mode(SPI_MODE1);
        queue_random(CHUNK_ITEMS);
        wait_drained();

        write_spi_mode(SPI_MODE2);
        queue_random(CHUNK_ITEMS);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_spi_mode(SPI_MODE0);
        queue_random(CHUNK_ITEMS);
        wait_drained();

        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && predicted_outputs.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
